// ===== hw/rtl/stbs_pkg.sv =====
// Shared constants and codes for the sorted table binary search block.
// No dependencies; the interfaces, the top level and the checker import this package.
package stbs_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int IDX_W     = 10;
    localparam int POS_W     = 10;
    localparam int CNT_W     = 11;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE  = 1'd1;

    // request operations
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // probe rules
    localparam logic [MODE_W-1:0] MODE_CLASSIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT   = 2'd2;

endpackage

// ===== hw/rtl/stbs_if.sv =====
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on stbs_pkg for field widths.
interface stbs_req_if import stbs_pkg::*; #(
    parameter int DW = DATA_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [IDX_W-1:0]     entry_index;
    logic signed [DW-1:0] value;

    modport source (output valid, output operation, output entry_index, output value,
                    input ready);
    modport sink   (input valid, input operation, input entry_index, input value,
                    output ready);
endinterface

interface stbs_res_if import stbs_pkg::*;;
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

interface stbs_cfg_if import stbs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Sorted table binary search: table RAM, probe sequencer and result register.
// Depends on stbs_pkg, stbs_if (channel interfaces) and stbs_ram.
//
// The table lives in one RAM with a registered read. A write request gives no
// result. A search accepts the request, then makes its probes, each one an
// address issue and then a compare of the read data, and last hands off to
// the result register. The classic mode makes at most floor(log2(n)) + 1
// probes for n entries in use; the leftmost and rightmost modes make
// ceil(log2(n)) + 1, the last one being the check of the converged position.
// An empty table makes no probe. Probes go one at a time through the single
// read port. A finished result sits in an output register, so write requests
// are taken while it waits; the next search starts at once but holds its
// result until the register is free.
// entry_count above DEPTH searches DEPTH entries; match_mode 3 acts as mode 0.
module sorted_table_binary_search import stbs_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    stbs_cfg_if.sink      i_cfg,
    stbs_req_if.sink      i_req,
    stbs_res_if.source    o_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [MODE_W-1:0]            r_mode, n_mode;
    logic                         r_out_valid, n_out_valid;
    logic [AW-1:0]                r_lo, n_lo;
    logic [AW-1:0]                r_hi, n_hi;
    logic [AW-1:0]                r_mid, n_mid;
    logic                         r_fin, n_fin;
    logic signed [DATA_WIDTH-1:0] r_key, n_key;
    logic                         r_hit, n_hit;
    logic [AW-1:0]                r_pos, n_pos;
    logic                         r_out_found, n_out_found;
    logic [POS_W-1:0]             r_out_pos, n_out_pos;

    logic [MODE_W-1:0]            w_mode;
    logic                         w_req_acc;
    logic                         w_out_free;
    logic [31:0]                  w_cnt_ext;
    logic [31:0]                  w_cnt;
    logic [31:0]                  w_last;
    logic [31:0]                  w_idx_ext;
    logic [31:0]                  w_pos_ext;
    logic                         w_wr_ok;
    logic [AW:0]                  w_span;
    logic [AW-1:0]                w_mid;
    logic                         w_ram_we;
    logic                         w_ram_re;
    logic [AW-1:0]                w_raddr;
    logic [DATA_WIDTH-1:0]        w_rdata;
    logic signed [DATA_WIDTH-1:0] w_entry;

    stbs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (DATA_WIDTH'(i_req.value)),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_cfg.ready    = 1'b1;
    assign i_req.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_out_found;
    assign o_res.position = r_out_pos;

    assign w_mode     = (r_mode == MODE_LEFT || r_mode == MODE_RIGHT) ? r_mode : MODE_CLASSIC;
    assign w_req_acc  = i_req.valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || o_res.ready;

    assign w_cnt_ext = 32'(r_count);
    assign w_cnt     = (w_cnt_ext > 32'(DEPTH)) ? 32'(DEPTH) : w_cnt_ext;
    assign w_last    = w_cnt - 32'd1;
    assign w_idx_ext = 32'(i_req.entry_index);
    assign w_wr_ok   = (w_idx_ext < 32'(DEPTH));
    assign w_pos_ext = 32'(r_pos);

    // lower mid, or upper mid for the rightmost rule
    assign w_span = ({1'b0, r_hi} - {1'b0, r_lo})
                  + ((w_mode == MODE_RIGHT) ? (AW+1)'(1) : (AW+1)'(0));
    assign w_mid  = r_lo + w_span[AW:1];

    assign w_ram_we = w_req_acc && (i_req.operation == OP_WRITE) && w_wr_ok;
    assign w_ram_re = (r_state == S_ISSUE);
    assign w_raddr  = (w_mode != MODE_CLASSIC && r_lo == r_hi) ? r_lo : w_mid;
    assign w_entry  = $signed(w_rdata);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_mode      = r_mode;
        n_out_valid = r_out_valid && !o_res.ready;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_fin       = r_fin;
        n_key       = r_key;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_out_found = r_out_found;
        n_out_pos   = r_out_pos;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ENTRY_COUNT: n_count = i_cfg.data[CNT_W-1:0];
                CFG_MATCH_MODE:  n_mode  = i_cfg.data[MODE_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_req_acc && i_req.operation == OP_SEARCH) begin
                    n_key = DATA_WIDTH'(i_req.value);
                    n_lo  = '0;
                    n_hi  = w_last[AW-1:0];
                    n_fin = 1'b0;
                    if (r_count == '0) begin
                        n_hit   = 1'b0;
                        n_pos   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_mid   = w_raddr;
                n_fin   = (w_mode != MODE_CLASSIC) && (r_lo == r_hi);
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_ISSUE;
                if (r_fin) begin
                    n_hit   = (w_entry == r_key);
                    n_pos   = (w_entry == r_key) ? r_lo : '0;
                    n_state = S_DONE;
                end else begin
                    case (w_mode)
                        MODE_LEFT: begin
                            if (w_entry < r_key) begin
                                n_lo = r_mid + AW'(1);
                            end else begin
                                n_hi = r_mid;
                            end
                        end
                        MODE_RIGHT: begin
                            if (w_entry > r_key) begin
                                n_hi = r_mid - AW'(1);
                            end else begin
                                n_lo = r_mid;
                            end
                        end
                        default: begin
                            n_hit = 1'b0;
                            n_pos = '0;
                            if (w_entry == r_key) begin
                                n_hit   = 1'b1;
                                n_pos   = r_mid;
                                n_state = S_DONE;
                            end else if (w_entry < r_key) begin
                                // range empty once the probe sat on the top end
                                if (r_mid == r_hi) begin
                                    n_state = S_DONE;
                                end else begin
                                    n_lo = r_mid + AW'(1);
                                end
                            end else begin
                                if (r_mid == r_lo) begin
                                    n_state = S_DONE;
                                end else begin
                                    n_hi = r_mid - AW'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_hit;
                    n_out_pos   = w_pos_ext[POS_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mode      <= MODE_CLASSIC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_fin       <= n_fin;
        r_key       <= n_key;
        r_hit       <= n_hit;
        r_pos       <= n_pos;
        r_out_found <= n_out_found;
        r_out_pos   <= n_out_pos;
    end

endmodule

// ===== hw/rtl/stbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== hw/rtl/stbs_checker.sv =====
// Port-level assertions for the sorted table binary search block, bound to it.
// Depends on stbs_pkg and on the top level sorted_table_binary_search.
module stbs_checker import stbs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_req_operation,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic             i_res_found,
    input logic [POS_W-1:0] i_res_position
);

    // the block is busy in the cycle after a search request
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_operation == OP_SEARCH) |=> !i_req_ready)
        else $error("request ready right after a search request");

    // the block is ready again in the cycle after a write request
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_operation == OP_WRITE) |=> i_req_ready)
        else $error("block busy after a write request");

    // a miss always reports position zero
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_found) |-> (i_res_position == '0))
        else $error("miss with nonzero position");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> ($stable(i_res_found) && $stable(i_res_position)))
        else $error("result payload changed while stalled");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_operation (i_req.operation),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_found     (o_res.found),
    .i_res_position  (o_res.position)
);
